[src/cpu8_pkg.sv]
// ---------------------------------------------------------------------------
// cpu8_pkg: shared types and constants
// Item and result layouts, command codes, register file and stack types for
// the 8-bit instruction execute block.
// ---------------------------------------------------------------------------
package cpu8_pkg;

  localparam logic [7:0] SP_RESET = 8'hFF;
  localparam int unsigned BANK_AW = 7;
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

  typedef enum logic [5:0] {
    CMD_LDA = 6'd0,  CMD_LDX = 6'd1,  CMD_LDY = 6'd2,  CMD_STA = 6'd3,
    CMD_STX = 6'd4,  CMD_STY = 6'd5,  CMD_TAX = 6'd6,  CMD_TAY = 6'd7,
    CMD_TXA = 6'd8,  CMD_TYA = 6'd9,  CMD_AND = 6'd10, CMD_ORA = 6'd11,
    CMD_EOR = 6'd12, CMD_ROL = 6'd13, CMD_ROR = 6'd14, CMD_ASL = 6'd15,
    CMD_LSR = 6'd16, CMD_CMP = 6'd17, CMD_CPX = 6'd18, CMD_CPY = 6'd19,
    CMD_INC = 6'd20, CMD_INX = 6'd21, CMD_INY = 6'd22, CMD_DEC = 6'd23,
    CMD_DEX = 6'd24, CMD_DEY = 6'd25, CMD_BIT = 6'd26, CMD_JMP = 6'd27,
    CMD_JSR = 6'd28, CMD_RTS = 6'd29, CMD_BCC = 6'd30, CMD_BCS = 6'd31,
    CMD_BEQ = 6'd32, CMD_BMI = 6'd33, CMD_BNE = 6'd34, CMD_BPL = 6'd35,
    CMD_BVC = 6'd36, CMD_BVS = 6'd37, CMD_CLC = 6'd38, CMD_CLD = 6'd39,
    CMD_CLI = 6'd40, CMD_CLV = 6'd41, CMD_SEC = 6'd42, CMD_SED = 6'd43,
    CMD_SEI = 6'd44, CMD_TSX = 6'd45, CMD_TXS = 6'd46, CMD_PHA = 6'd47,
    CMD_PHP = 6'd48, CMD_PLA = 6'd49, CMD_PLP = 6'd50, CMD_NOP = 6'd51
  } cmd_e;

  typedef struct packed {
    logic n;
    logic v;
    logic d;
    logic i;
    logic z;
    logic c;
  } flag_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    flag_t      flags;
  } arch_t;

  typedef struct packed {
    logic [5:0]  command;
    logic        on_memory;
    logic [7:0]  operand;
    logic [15:0] address;
    logic [15:0] next_pc;
  } item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_ptr;
    logic [7:0]  flags;
    logic [15:0] pc;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  mem_data;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } stk_wr_t;

  // commands that need stack bytes read before they can execute
  function automatic logic is_pull(logic [5:0] cmd);
    return (cmd == CMD_RTS) || (cmd == CMD_PLA) || (cmd == CMD_PLP);
  endfunction

endpackage

[src/cpu8_stream_if.sv]
// ---------------------------------------------------------------------------
// cpu8_stream_if: valid/ready channel
// Carries one payload item per handshake from a source to a sink.
// ---------------------------------------------------------------------------
interface cpu8_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/cpu8_stk_ram.sv]
// ---------------------------------------------------------------------------
// cpu8_stk_ram: one bank of the stack page
// Single write port, single read port with registered read data.
// ---------------------------------------------------------------------------
module cpu8_stk_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [cpu8_pkg::BANK_AW-1:0] waddr_i,
  input  logic [7:0]                  wdata_i,
  input  logic [cpu8_pkg::BANK_AW-1:0] raddr_i,
  output logic [7:0]                  rdata_o
);
  import cpu8_pkg::*;

  logic [7:0] mem [BANK_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/cpu8_exec.sv]
// ---------------------------------------------------------------------------
// cpu8_exec: instruction execute logic
// Computes next register state, result fields and stack writes for one
// decoded instruction.
// ---------------------------------------------------------------------------
module cpu8_exec (
  input  cpu8_pkg::item_t   item_i,
  input  cpu8_pkg::arch_t   st_i,
  input  logic [7:0]        pull_lo_i,
  input  logic [7:0]        pull_hi_i,
  output cpu8_pkg::arch_t   st_o,
  output cpu8_pkg::result_t res_o,
  output cpu8_pkg::stk_wr_t wr0_o,
  output cpu8_pkg::stk_wr_t wr1_o
);
  import cpu8_pkg::*;

  function automatic flag_t with_nz(flag_t f, logic [7:0] v);
    flag_t r;
    r = f;
    r.n = v[7];
    r.z = (v == 8'd0);
    return r;
  endfunction

  always_comb begin
    arch_t       st;
    logic [15:0] pc;
    logic        wr;
    logic [7:0]  wdata;
    logic [7:0]  op;
    logic [7:0]  src;
    logic [7:0]  sh_v;
    logic        sh_c;
    logic        do_sh;
    logic [7:0]  cmp_r;
    logic        do_cmp;
    logic [8:0]  diff;
    logic [7:0]  v;
    logic [15:0] ret;
    logic        taken;

    st     = st_i;
    pc     = item_i.next_pc;
    wr     = 1'b0;
    wdata  = 8'd0;
    op     = item_i.operand;
    src    = item_i.on_memory ? item_i.operand : st_i.acc;
    sh_v   = 8'd0;
    sh_c   = 1'b0;
    do_sh  = 1'b0;
    cmp_r  = 8'd0;
    do_cmp = 1'b0;
    v      = 8'd0;
    ret    = item_i.next_pc - 16'd1;
    taken  = 1'b0;
    wr0_o  = '0;
    wr1_o  = '0;

    case (cmd_e'(item_i.command))
      CMD_LDA: begin st.acc = op; st.flags = with_nz(st.flags, op); end
      CMD_LDX: begin st.x = op; st.flags = with_nz(st.flags, op); end
      CMD_LDY: begin st.y = op; st.flags = with_nz(st.flags, op); end
      CMD_STA: begin wr = 1'b1; wdata = st_i.acc; end
      CMD_STX: begin wr = 1'b1; wdata = st_i.x; end
      CMD_STY: begin wr = 1'b1; wdata = st_i.y; end
      CMD_TAX: begin st.x = st_i.acc; st.flags = with_nz(st.flags, st_i.acc); end
      CMD_TAY: begin st.y = st_i.acc; st.flags = with_nz(st.flags, st_i.acc); end
      CMD_TXA: begin st.acc = st_i.x; st.flags = with_nz(st.flags, st_i.x); end
      CMD_TYA: begin st.acc = st_i.y; st.flags = with_nz(st.flags, st_i.y); end
      CMD_AND: begin
        st.acc   = st_i.acc & op;
        st.flags = with_nz(st.flags, st_i.acc & op);
      end
      CMD_ORA: begin
        st.acc   = st_i.acc | op;
        st.flags = with_nz(st.flags, st_i.acc | op);
      end
      CMD_EOR: begin
        st.acc   = st_i.acc ^ op;
        st.flags = with_nz(st.flags, st_i.acc ^ op);
      end
      CMD_ROL: begin sh_v = {src[6:0], st_i.flags.c}; sh_c = src[7]; do_sh = 1'b1; end
      CMD_ROR: begin sh_v = {st_i.flags.c, src[7:1]}; sh_c = src[0]; do_sh = 1'b1; end
      CMD_ASL: begin sh_v = {src[6:0], 1'b0}; sh_c = src[7]; do_sh = 1'b1; end
      CMD_LSR: begin sh_v = {1'b0, src[7:1]}; sh_c = src[0]; do_sh = 1'b1; end
      CMD_CMP: begin cmp_r = st_i.acc; do_cmp = 1'b1; end
      CMD_CPX: begin cmp_r = st_i.x; do_cmp = 1'b1; end
      CMD_CPY: begin cmp_r = st_i.y; do_cmp = 1'b1; end
      CMD_INC: begin
        v = op + 8'd1;
        st.flags = with_nz(st.flags, v);
        wr = 1'b1;
        wdata = v;
      end
      CMD_INX: begin st.x = st_i.x + 8'd1; st.flags = with_nz(st.flags, st_i.x + 8'd1); end
      CMD_INY: begin st.y = st_i.y + 8'd1; st.flags = with_nz(st.flags, st_i.y + 8'd1); end
      CMD_DEC: begin
        v = op - 8'd1;
        st.flags = with_nz(st.flags, v);
        wr = 1'b1;
        wdata = v;
      end
      CMD_DEX: begin st.x = st_i.x - 8'd1; st.flags = with_nz(st.flags, st_i.x - 8'd1); end
      CMD_DEY: begin st.y = st_i.y - 8'd1; st.flags = with_nz(st.flags, st_i.y - 8'd1); end
      CMD_BIT: begin
        st.flags.n = op[7];
        st.flags.v = op[6];
        st.flags.z = ((st_i.acc & op) == 8'd0);
      end
      CMD_JMP: pc = item_i.address;
      CMD_JSR: begin
        // return address minus one, high byte pushed first
        wr0_o = '{en: 1'b1, addr: st_i.sp, data: ret[15:8]};
        wr1_o = '{en: 1'b1, addr: st_i.sp - 8'd1, data: ret[7:0]};
        st.sp = st_i.sp - 8'd2;
        pc    = item_i.address;
      end
      CMD_RTS: begin
        st.sp = st_i.sp + 8'd2;
        pc    = {pull_hi_i, pull_lo_i} + 16'd1;
      end
      CMD_BCC: taken = !st_i.flags.c;
      CMD_BCS: taken = st_i.flags.c;
      CMD_BEQ: taken = st_i.flags.z;
      CMD_BMI: taken = st_i.flags.n;
      CMD_BNE: taken = !st_i.flags.z;
      CMD_BPL: taken = !st_i.flags.n;
      CMD_BVC: taken = !st_i.flags.v;
      CMD_BVS: taken = st_i.flags.v;
      CMD_CLC: st.flags.c = 1'b0;
      CMD_CLD: st.flags.d = 1'b0;
      CMD_CLI: st.flags.i = 1'b0;
      CMD_CLV: st.flags.v = 1'b0;
      CMD_SEC: st.flags.c = 1'b1;
      CMD_SED: st.flags.d = 1'b1;
      CMD_SEI: st.flags.i = 1'b1;
      CMD_TSX: begin st.x = st_i.sp; st.flags = with_nz(st.flags, st_i.sp); end
      CMD_TXS: st.sp = st_i.x;
      CMD_PHA: begin
        wr0_o = '{en: 1'b1, addr: st_i.sp, data: st_i.acc};
        st.sp = st_i.sp - 8'd1;
      end
      CMD_PHP: begin
        // pushed status carries B and bit 5 set
        wr0_o = '{en: 1'b1, addr: st_i.sp,
                  data: {st_i.flags.n, st_i.flags.v, 2'b11, st_i.flags.d,
                         st_i.flags.i, st_i.flags.z, st_i.flags.c}};
        st.sp = st_i.sp - 8'd1;
      end
      CMD_PLA: begin
        st.sp    = st_i.sp + 8'd1;
        st.acc   = pull_lo_i;
        st.flags = with_nz(st.flags, pull_lo_i);
      end
      CMD_PLP: begin
        st.sp    = st_i.sp + 8'd1;
        st.flags = '{n: pull_lo_i[7], v: pull_lo_i[6], d: pull_lo_i[3],
                     i: pull_lo_i[2], z: pull_lo_i[1], c: pull_lo_i[0]};
      end
      CMD_NOP: ;
      default: ;
    endcase

    if (taken) begin
      pc = item_i.address;
    end

    if (do_sh) begin
      st.flags   = with_nz(st.flags, sh_v);
      st.flags.c = sh_c;
      if (item_i.on_memory) begin
        wr    = 1'b1;
        wdata = sh_v;
      end else begin
        st.acc = sh_v;
      end
    end

    if (do_cmp) begin
      diff       = {1'b0, cmp_r} - {1'b0, op};
      st.flags   = with_nz(st.flags, diff[7:0]);
      st.flags.c = !diff[8];
    end else begin
      diff = 9'd0;
    end

    st_o            = st;
    res_o.acc       = st.acc;
    res_o.index_x   = st.x;
    res_o.index_y   = st.y;
    res_o.stack_ptr = st.sp;
    res_o.flags     = {st.flags.n, st.flags.v, 2'b10, st.flags.d, st.flags.i,
                       st.flags.z, st.flags.c};
    res_o.pc        = pc;
    res_o.mem_write = wr;
    res_o.mem_addr  = wr ? item_i.address : 16'd0;
    res_o.mem_data  = wr ? wdata : 8'd0;
  end

endmodule

[src/cpu8_instruction_execute.sv]
// ---------------------------------------------------------------------------
// cpu8_instruction_execute: 8-bit instruction execute unit
// Runs one decoded instruction per item against A, X, Y, SP, flags and an
// internal stack page; reports registers, next pc and any memory write.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  carries decoded items (command, on_memory, operand, address,
//         next_pc); out_o carries one result item per input item, in order.
//   An accepted item is registered in the input register and its result
//   then in the output register; a pull or a stalled receiver can hold
//   it in the input register between the two.
//   Throughput is one item per cycle unless the receiver stalls or a
//   pull waits. RTS, PLA and PLP wait in the input register, in_i.ready
//   low, until the two stack banks, split by address parity, deliver
//   their registered read data; JSR writes both banks in the same cycle.
//   When the receiver stalls the result holds in the output register and
//   one more item is still taken into the input register; after that
//   in_i.ready drops until the result is taken.
//   Reset clears A, X, Y and the flags, sets SP to 0xFF and empties both
//   registers. The stack page is not cleared; a pull of a never written
//   entry returns undefined data.
// ---------------------------------------------------------------------------
module cpu8_instruction_execute (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpu8_stream_if.sink   in_i,
  cpu8_stream_if.source out_o
);
  import cpu8_pkg::*;

  item_t   in_q;
  logic    in_vld_q;
  logic    rd_done_q;
  result_t out_q;
  logic    out_vld_q;
  arch_t   arch_q;

  arch_t   arch_d;
  result_t res_d;
  stk_wr_t wr0;
  stk_wr_t wr1;
  logic    pull;
  logic    exec_go;
  logic    in_take;

  logic [7:0]         sp1;
  logic [7:0]         sp2;
  logic [1:0]         bank_we;
  logic [BANK_AW-1:0] bank_waddr [2];
  logic [7:0]         bank_wdata [2];
  logic [BANK_AW-1:0] bank_raddr [2];
  logic [7:0]         bank_rdata [2];
  logic [7:0]         pull_lo;
  logic [7:0]         pull_hi;

  assign pull    = is_pull(in_q.command);
  assign exec_go = in_vld_q && (!pull || rd_done_q) && (!out_vld_q || out_o.ready);
  assign in_take = in_i.valid && in_i.ready;

  assign in_i.ready  = !in_vld_q || exec_go;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // stack banks: even and odd addresses, so two neighbors go at once
  assign sp1 = arch_q.sp + 8'd1;
  assign sp2 = arch_q.sp + 8'd2;

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      bank_raddr[b] = (sp1[0] == b[0]) ? sp1[7:1] : sp2[7:1];
      if (wr0.en && (wr0.addr[0] == b[0])) begin
        bank_we[b]    = exec_go;
        bank_waddr[b] = wr0.addr[7:1];
        bank_wdata[b] = wr0.data;
      end else begin
        bank_we[b]    = exec_go && wr1.en && (wr1.addr[0] == b[0]);
        bank_waddr[b] = wr1.addr[7:1];
        bank_wdata[b] = wr1.data;
      end
    end
  end

  assign pull_lo = bank_rdata[sp1[0]];
  assign pull_hi = bank_rdata[sp2[0]];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    cpu8_stk_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (bank_waddr[b]),
      .wdata_i (bank_wdata[b]),
      .raddr_i (bank_raddr[b]),
      .rdata_o (bank_rdata[b])
    );
  end

  cpu8_exec u_exec (
    .item_i    (in_q),
    .st_i      (arch_q),
    .pull_lo_i (pull_lo),
    .pull_hi_i (pull_hi),
    .st_o      (arch_d),
    .res_o     (res_d),
    .wr0_o     (wr0),
    .wr1_o     (wr1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      rd_done_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      arch_q.acc   <= 8'd0;
      arch_q.x     <= 8'd0;
      arch_q.y     <= 8'd0;
      arch_q.sp    <= SP_RESET;
      arch_q.flags <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (exec_go) begin
        in_vld_q <= 1'b0;
      end
      // stack read data is ready once the banks have registered a pull's read
      if (exec_go) begin
        rd_done_q <= 1'b0;
      end else if (in_vld_q && pull) begin
        rd_done_q <= 1'b1;
      end
      if (exec_go) begin
        out_vld_q <= 1'b1;
        arch_q    <= arch_d;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_i.data;
    end
    if (exec_go) begin
      out_q <= res_d;
    end
  end

endmodule

[src/cpu8_exec_checker.sv]
// ---------------------------------------------------------------------------
// cpu8_exec_checker: port checks for the execute unit
// Watches the result channel of the top level; attached by bind.
// ---------------------------------------------------------------------------
module cpu8_exec_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input cpu8_pkg::result_t out_data_i
);
  import cpu8_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result item changed while stalled");

  a_flag_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.flags[5] && !out_data_i.flags[4])
    else $error("status bit 5 or B wrong in result item");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.mem_write |->
      (out_data_i.mem_addr == 16'd0) && (out_data_i.mem_data == 8'd0))
    else $error("memory fields set without a write");

endmodule

bind cpu8_instruction_execute cpu8_exec_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
